// File: src/adcsma_pkg.sv
package adcsma_pkg;

  // Field widths of the sample and result transactions.
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned VOLT_W   = 24;
  localparam int unsigned GAIN_W   = 3;

  // Full scale in microvolts fits 23 unsigned bits.
  localparam int unsigned FS_W   = 23;
  // Signed product of sample and full scale.
  localparam int unsigned PROD_W = SAMPLE_W + FS_W;
  // Magnitude of that product, and the dividend width of the divider.
  localparam int unsigned MAG_W  = PROD_W - 1;
  localparam int unsigned DIV_W  = MAG_W;
  // Divisor width: holds any fill count.
  localparam int unsigned DVS_W  = 16;
  // Sample bits below the sign; the full code is 2**CODE_W - 1.
  localparam int unsigned CODE_W = SAMPLE_W - 1;

  localparam logic [DVS_W-1:0]  FULL_CODE  = 16'd32767;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd1;

  // Gain index codes.
  localparam logic [GAIN_W-1:0] GAIN_6V144 = 3'd0;
  localparam logic [GAIN_W-1:0] GAIN_4V096 = 3'd1;
  localparam logic [GAIN_W-1:0] GAIN_2V048 = 3'd2;
  localparam logic [GAIN_W-1:0] GAIN_1V024 = 3'd3;
  localparam logic [GAIN_W-1:0] GAIN_0V512 = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] raw_sample;
  } in_t;

  typedef struct packed {
    logic signed [VOLT_W-1:0] voltage_uv;
    logic [CHAN_W-1:0]        channel_out;
  } out_t;

  // Full scale in microvolts; all indices above the 0.512 V code mean 0.256 V.
  function automatic logic [FS_W-1:0] full_scale_uv(input logic [GAIN_W-1:0] gain);
    logic [FS_W-1:0] fs;
    case (gain)
      GAIN_6V144: fs = 23'd6144000;
      GAIN_4V096: fs = 23'd4096000;
      GAIN_2V048: fs = 23'd2048000;
      GAIN_1V024: fs = 23'd1024000;
      GAIN_0V512: fs = 23'd512000;
      default:    fs = 23'd256000;
    endcase
    return fs;
  endfunction

endpackage

// File: src/adc_scale_moving_average.sv
// Converter sample scaling with a moving average on channels 0 and 1. Each sample
// transaction is scaled to microvolts (raw * full scale / 32767, truncated toward
// zero) and one result transaction follows. Channels 2 and 3 return the scaled
// value; channels 0 and 1 return the truncated mean over the last WINDOW samples
// of that channel, or over fewer while the ring is still filling. One item is in
// work at a time. The division by 32767 folds the product bits above bit 14 back
// onto the low bits, one fold per cycle and at most three. The next sample is
// taken once the result has moved into the output register. An averaged item
// adds the ring update and the mean on a bit-serial divider. While the output
// register holds a stalled result, a new result waits in the sequencer until it
// frees. The rings live in one memory of 2*WINDOW entries with a registered read
// port; a finished result waits in the output register while the next sample is
// taken.
module adc_scale_moving_average #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  adcsma_pkg::in_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output adcsma_pkg::out_t                out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adcsma_pkg::GAIN_W-1:0]   cfg_data
);
  import adcsma_pkg::*;

  localparam int unsigned DEPTH  = 2 * WINDOW;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = VOLT_W + $clog2(WINDOW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE_START,
    S_SCALE_DIV,
    S_UPDATE,
    S_AVG_START,
    S_AVG_DIV,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [CHAN_W-1:0]        chan_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VOLT_W-1:0] scaled_r;
  logic signed [VOLT_W-1:0] result_r;
  logic                     avg_neg_r;
  logic [ADDR_W-1:0]        addr_r;

  // Folding division by the full code.
  logic [MAG_W-1:0]         fold_r;
  logic [VOLT_W-1:0]        fold_acc_r;

  // Per-channel ring control for the two averaged channels.
  logic [PTR_W-1:0]         ptr_r [2];
  logic [CNT_W-1:0]         cnt_r [2];
  logic signed [SUM_W-1:0]  sum_r [2];

  // Ring memory.
  logic [VOLT_W-1:0]        ring_mem [DEPTH];
  logic [VOLT_W-1:0]        rd_data_r;
  logic                     rd_en;
  logic                     wr_en;

  // Divider for the mean.
  logic                     div_start_r;
  logic [DIV_W-1:0]         div_dividend_r;
  logic [DVS_W-1:0]         div_divisor_r;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quot;

  logic                     out_valid_r;
  out_t                     out_data_r;

  // Scaling product and its magnitude.
  logic signed [PROD_W:0]   raw_ext;
  logic signed [PROD_W:0]   fs_ext;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod_abs;

  // Fold terms.
  logic [MAG_W-CODE_W-1:0]  fold_hi;
  logic [MAG_W-1:0]         fold_sum;
  logic                     fold_busy;
  logic [VOLT_W-1:0]        scale_mag;
  logic signed [VOLT_W-1:0] scale_signed;

  // Ring update terms.
  logic                     ch_sel;
  logic                     ring_full;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [PTR_W-1:0]         ptr_nxt;
  logic signed [SUM_W-1:0]  sum_abs;
  logic [ADDR_W-1:0]        addr_nxt;
  logic signed [VOLT_W-1:0] quot_signed;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Gain register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_data;
    end
  end

  // Sample times full scale, registered before the division.
  always_comb begin
    raw_ext   = (PROD_W + 1)'(in_data.raw_sample);
    fs_ext    = $signed({{(PROD_W + 1 - FS_W){1'b0}}, full_scale_uv(gain_r)});
    prod_full = raw_ext * fs_ext;
    prod_abs  = prod_r[PROD_W-1] ? -prod_r : prod_r;
  end

  // Since 2**15 = 32767 + 1, moving the bits above bit 14 onto the low bits
  // keeps magnitude = 32767 * accumulated + fold. Once the fold is below 2**15
  // it is the remainder, unless it equals the full code itself.
  always_comb begin
    fold_hi      = fold_r[MAG_W-1:CODE_W];
    fold_sum     = MAG_W'(fold_hi) + MAG_W'(fold_r[CODE_W-1:0]);
    fold_busy    = (fold_hi != '0);
    scale_mag    = fold_acc_r + ((fold_r == MAG_W'(FULL_CODE)) ? VOLT_W'(1) : VOLT_W'(0));
    scale_signed = $signed(scale_mag);
  end

  // Ring arithmetic for the channel in work.
  always_comb begin
    ch_sel    = chan_r[0];
    ring_full = (cnt_r[ch_sel] == CNT_W'(WINDOW));
    sum_nxt   = sum_r[ch_sel] + SUM_W'(scaled_r)
                - (ring_full ? SUM_W'($signed(rd_data_r)) : SUM_W'(0));
    cnt_nxt   = ring_full ? cnt_r[ch_sel] : cnt_r[ch_sel] + 1'b1;
    ptr_nxt   = (ptr_r[ch_sel] == PTR_W'(WINDOW - 1)) ? '0 : ptr_r[ch_sel] + 1'b1;
    sum_abs   = sum_r[ch_sel][SUM_W-1] ? -sum_r[ch_sel] : sum_r[ch_sel];
    addr_nxt  = chan_r[0] ? ADDR_W'(WINDOW) + ADDR_W'(ptr_r[chan_r[0]])
                          : ADDR_W'(ptr_r[chan_r[0]]);
    quot_signed = $signed(div_quot[VOLT_W-1:0]);
  end

  assign rd_en = (state_r == S_SCALE_START);
  assign wr_en = (state_r == S_UPDATE);

  // Ring memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[addr_r] <= scaled_r;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[addr_nxt];
    end
  end

  adcsma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend_r),
    .divisor  (div_divisor_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer: scale, read-modify-write of the ring, average, deliver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        ptr_r[i] <= '0;
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            chan_r  <= in_data.channel;
            prod_r  <= prod_full[PROD_W-1:0];
            state_r <= S_SCALE_START;
          end
        end
        S_SCALE_START: begin
          fold_r     <= prod_abs[MAG_W-1:0];
          fold_acc_r <= '0;
          addr_r     <= addr_nxt;
          state_r    <= S_SCALE_DIV;
        end
        S_SCALE_DIV: begin
          // Fold until the magnitude is below 2**15, then apply the sign.
          if (fold_busy) begin
            fold_acc_r <= fold_acc_r + VOLT_W'(fold_hi);
            fold_r     <= fold_sum;
          end else if (chan_r[1]) begin
            result_r <= prod_r[PROD_W-1] ? -scale_signed : scale_signed;
            state_r  <= S_DONE;
          end else begin
            scaled_r <= prod_r[PROD_W-1] ? -scale_signed : scale_signed;
            state_r  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          sum_r[ch_sel] <= sum_nxt;
          cnt_r[ch_sel] <= cnt_nxt;
          ptr_r[ch_sel] <= ptr_nxt;
          state_r       <= S_AVG_START;
        end
        S_AVG_START: begin
          div_start_r    <= 1'b1;
          div_dividend_r <= DIV_W'($unsigned(sum_abs));
          div_divisor_r  <= DVS_W'(cnt_r[ch_sel]);
          avg_neg_r      <= sum_r[ch_sel][SUM_W-1];
          state_r        <= S_AVG_DIV;
        end
        S_AVG_DIV: begin
          if (div_done) begin
            result_r <= avg_neg_r ? -quot_signed : quot_signed;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          // The result register frees when its transaction completes.
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_data_r.voltage_uv  <= result_r;
            out_data_r.channel_out <= chan_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/adcsma_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module adcsma_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [adcsma_pkg::DIV_W-1:0] dividend,
  input  logic [adcsma_pkg::DVS_W-1:0] divisor,
  output logic                        done,
  output logic [adcsma_pkg::DIV_W-1:0] quotient
);
  import adcsma_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quot_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             take;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    shifted = {rem_r, quot_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    take    = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quot_r <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        quot_r <= {quot_r[DIV_W-2:0], take};
        rem_r  <= take ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// File: bench/tb_adc_scale_moving_average.sv
`timescale 1ns / 100ps

module tb_adc_scale_moving_average;
  import adcsma_pkg::*;

  localparam int unsigned AVG_WINDOW   = 10;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned PHASE_COUNT  = 10;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam longint      CYCLE_LIMIT  = 600000;

  // Gain codes above the 0.512 V code all select 0.256 V.
  localparam logic [GAIN_W-1:0] GAIN_0V256      = 3'd5;
  localparam logic [GAIN_W-1:0] GAIN_0V256_ALT6 = 3'd6;
  localparam logic [GAIN_W-1:0] GAIN_0V256_ALT7 = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_t;

  // Scoreboard: keeps its own copy of the gain and the two averaging rings, and
  // queues the expected result for every accepted sample transaction.
  class avg_scoreboard_t;
    logic [GAIN_W-1:0] gain;
    longint            ring[2][AVG_WINDOW];
    int                wptr[2];
    int                fill[2];
    longint            sum[2];
    out_t              expected_q[$];
    int                errors;
    int                samples_seen;
    int                results_seen;

    function new();
      gain = GAIN_RESET;
      for (int c = 0; c < 2; c++) begin
        wptr[c] = 0;
        fill[c] = 0;
        sum[c]  = 0;
        for (int k = 0; k < AVG_WINDOW; k++) ring[c][k] = 0;
      end
      errors       = 0;
      samples_seen = 0;
      results_seen = 0;
    endfunction

    function void set_gain(logic [GAIN_W-1:0] g);
      gain = g;
    endfunction

    function longint full_scale(logic [GAIN_W-1:0] g);
      case (g)
        GAIN_6V144: return 6144000;
        GAIN_4V096: return 4096000;
        GAIN_2V048: return 2048000;
        GAIN_1V024: return 1024000;
        GAIN_0V512: return 512000;
        default:    return 256000;
      endcase
    endfunction

    function void note_input(in_t item);
      longint v;
      int     ch;
      int     slot;
      out_t   want;
      // Scale to microvolts; signed division truncates toward zero.
      v  = (longint'($signed(item.raw_sample)) * full_scale(gain)) / 64'sd32767;
      ch = item.channel;
      // Channels 0 and 1 go through the moving average.
      if (ch < 2) begin
        slot = wptr[ch];
        if (fill[ch] >= AVG_WINDOW) sum[ch] -= ring[ch][slot];
        else fill[ch]++;
        ring[ch][slot] = v;
        sum[ch] += v;
        wptr[ch] = (slot + 1 >= AVG_WINDOW) ? 0 : slot + 1;
        v = sum[ch] / longint'(fill[ch]);
      end
      want.voltage_uv  = v[VOLT_W-1:0];
      want.channel_out = item.channel;
      expected_q.push_back(want);
      samples_seen++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no pending sample: voltage_uv %0d, channel_out %0d",
               $signed(got.voltage_uv), got.channel_out);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.voltage_uv !== want.voltage_uv) begin
        $error("voltage_uv mismatch: expected %0d, actual %0d",
               $signed(want.voltage_uv), $signed(got.voltage_uv));
        errors++;
      end
      if (got.channel_out !== want.channel_out) begin
        $error("channel_out mismatch: expected %0d, actual %0d",
               want.channel_out, got.channel_out);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [GAIN_W-1:0] cfg_data;

  avg_scoreboard_t sb = new();
  longint          cycle_count = 0;
  int              gain_writes = 0;

  adc_scale_moving_average #(
    .WINDOW(AVG_WINDOW)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run-time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result monitor: every accepted result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver back-pressure: random stall modes, plus one long hold-off that
  // lets the block fill up and stall the sample channel.
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    bit          hold_done;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    mode_left = 100;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 400);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic in_t make_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] raw);
    in_t item;
    item.channel    = ch;
    item.raw_sample = raw;
    return item;
  endfunction

  // Random sample with extra weight on the code extremes and values near zero.
  function automatic in_t random_sample();
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] raw;
    ch = CHAN_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       raw = 16'sh7FFF;
      1:       raw = -16'sh8000;
      2:       raw = $signed(16'($urandom_range(0, 15))) - 16'sd8;
      3:       raw = $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
      default: raw = SAMPLE_W'($urandom);
    endcase
    return make_sample(ch, raw);
  endfunction

  // Offer a list of sample transactions, in bursts with gaps when asked.
  task automatic stream_items(input in_t items[$], input bit gappy);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 24);
    foreach (items[i]) begin
      in_valid <= 1'b1;
      in_data  <= items[i];
      do @(posedge clk); while (in_stall);
      sb.note_input(items[i]);
      burst_left--;
      if (gappy && burst_left == 0 && i != items.size() - 1) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Gain is changed only while no result is outstanding.
  task automatic write_gain(input logic [GAIN_W-1:0] g);
    while (sb.outstanding() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_gain(g);
    gain_writes++;
  endtask

  // Stimulus.
  initial begin
    in_t               items[$];
    logic [GAIN_W-1:0] gain_plan[PHASE_COUNT];
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gain: pass-through extremes, then overfill the channel 0 ring so
    // the oldest entries are retired from the sum.
    items.delete();
    items.push_back(make_sample(2'd2, 16'sh7FFF));
    items.push_back(make_sample(2'd3, -16'sh8000));
    items.push_back(make_sample(2'd2, 16'sd0));
    items.push_back(make_sample(2'd3, -16'sd1));
    items.push_back(make_sample(2'd1, 16'sh7FFF));
    items.push_back(make_sample(2'd1, -16'sh8000));
    repeat (5) items.push_back(make_sample(2'd0, 16'sh7FFF));
    repeat (3) items.push_back(make_sample(2'd0, -16'sh8000));
    items.push_back(make_sample(2'd0, 16'sd1));
    items.push_back(make_sample(2'd0, -16'sd1));
    items.push_back(make_sample(2'd0, 16'sd12345));
    items.push_back(make_sample(2'd0, -16'sh8000));
    stream_items(items, 1'b0);

    // Widest full scale: the most negative code goes past minus full scale.
    write_gain(GAIN_6V144);
    items.delete();
    items.push_back(make_sample(2'd2, -16'sh8000));
    items.push_back(make_sample(2'd3, 16'sh7FFF));
    items.push_back(make_sample(2'd0, -16'sh8000));
    items.push_back(make_sample(2'd1, 16'sd1));
    stream_items(items, 1'b0);

    // Top gain code aliases to 0.256 V.
    write_gain(GAIN_0V256_ALT7);
    items.delete();
    items.push_back(make_sample(2'd2, -16'sh8000));
    items.push_back(make_sample(2'd3, 16'sh7FFF));
    items.push_back(make_sample(2'd1, -16'sd5));
    stream_items(items, 1'b0);

    // Random phases, one gain setting each.
    gain_plan = '{GAIN_6V144, GAIN_0V256_ALT7, GAIN_1V024, GAIN_0V256, GAIN_2V048,
                  GAIN_0V256_ALT6, GAIN_0V512, GAIN_4V096, GAIN_RESET, GAIN_RESET};
    gain_plan[8] = GAIN_W'($urandom_range(0, 7));
    gain_plan[9] = GAIN_W'($urandom_range(0, 7));
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_gain(gain_plan[p]);
      items.delete();
      repeat (PHASE_ITEMS) items.push_back(random_sample());
      stream_items(items, (p % 3) != 2);
    end

    // Drain, then allow for anything the block still produces.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d sample and %0d result transactions over %0d gain writes,",
             sb.samples_seen, sb.results_seen, gain_writes);
    $display("with bursty input, random output stalls and one long output hold-off.");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
